@@ design/pdc_pkg.sv @@
// Shared types, register codes and constants of the deadband PID controller.
`timescale 1ns / 1ps

package pdc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEAD_BAND      = 3'd5;

    localparam logic signed [15:0] PROP_GAIN_RST      = 16'sd179;
    localparam logic signed [15:0] INTEG_GAIN_RST     = 16'sd0;
    localparam logic signed [15:0] DERIV_GAIN_RST     = 16'sd0;
    localparam logic [14:0]        OUTPUT_LIMIT_RST   = 15'd2867;
    localparam logic [14:0]        INTEGRAL_LIMIT_RST = 15'd1229;
    localparam logic [14:0]        DEAD_BAND_RST      = 15'd82;

    // shared multiplier: 34 x 18 signed
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // serial divider: 41-bit magnitude by 16-bit step time, one bit per cycle
    localparam int DIV_N_W   = 41;
    localparam int DIV_D_W   = 16;
    localparam int DIV_CNT_W = $clog2(DIV_N_W);

    typedef struct packed {
        logic signed [15:0] prop_gain;
        logic signed [15:0] integ_gain;
        logic signed [15:0] deriv_gain;
        logic [14:0]        output_limit;
        logic [14:0]        integral_limit;
        logic [14:0]        dead_band;
    } pdc_cfg_t;

    typedef struct packed {
        logic signed [15:0] setpoint;
        logic signed [15:0] measured;
        logic [15:0]        step_time;
    } pdc_in_t;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } pdc_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MUL_D,
        ST_DIV_GO,
        ST_MUL_I1,
        ST_MUL_I2,
        ST_INTEG,
        ST_WAIT_DIV,
        ST_SUM,
        ST_CLAMP,
        ST_DONE
    } pdc_state_t;

endpackage

@@ design/pid_deadband_clamped.sv @@
// Top level of the fixed-point PID controller with deadband and clamped integral.
`timescale 1ns / 1ps

// Usage:
//   Input channel in_valid / in_stall / in_item carries setpoint, measured and
//   step_time. An item is taken when in_valid is high and in_stall low.
//   Output channel out_valid / out_stall / out_item returns one drive value
//   and a saturated flag for every item, in order.
//   Config port: cfg_we, cfg_index, cfg_data write one of the six gain and
//   limit registers per write; write only while no item is in flight.
// Derivative: formed by the 41-step serial divider (kd * de * 256 / dt).
//   A zero step_time item skips all arithmetic and returns a zero drive.
// Flow: one item at a time; in_stall stays high from accept until the
//   result has been moved into the output register. A single shared
//   34x18 multiplier does all four products.
// Output stall: the result waits in the output register; the next item can
//   be accepted meanwhile, but its result is held back until the register
//   frees up.
// Reset: rst_n clears registers to their defaults, zeroes the integral and
//   the stored error, and empties the output register.

module pid_deadband_clamped
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pdc_in_t               in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pdc_out_t              out_item,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    pdc_cfg_t cfg;

    pdc_state_t state_reg, state_next;

    // controller state
    logic signed [16:0] prev_err_reg, prev_err_next;
    logic signed [31:0] acc_reg, acc_next;

    // per-item working registers
    pdc_in_t            in_reg, in_next;
    logic signed [16:0] err_reg, err_next;
    logic signed [24:0] p_reg, p_next;
    logic               d_neg_reg, d_neg_next;
    logic signed [42:0] sum_reg, sum_next;
    pdc_out_t           res_reg, res_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    pdc_out_t           out_item_reg, out_item_next;

    // shared units
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] prod;
    logic                      div_start;
    logic                      div_busy;
    logic [DIV_N_W-1:0]        div_mag;
    logic [DIV_N_W-1:0]        div_quo;

    // datapath terms
    logic signed [16:0]        e_raw;
    logic signed [16:0]        db17;
    logic                      in_band;
    logic signed [16:0]        e_dz;
    logic signed [17:0]        de;
    logic signed [MUL_P_W-1:0] prod_rnd;
    logic signed [41:0]        inc;
    logic signed [41:0]        acc_sum;
    logic signed [41:0]        ilim;
    logic signed [31:0]        acc_clamped;
    logic signed [33:0]        i_rnd;
    logic signed [16:0]        i_term;
    logic signed [41:0]        dvd;
    logic signed [41:0]        dvd_mag;
    logic signed [41:0]        d_term;
    logic signed [42:0]        olim;

    pdc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdc_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    pdc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_mag),
        .divisor  (in_reg.step_time),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // error with deadband
    assign e_raw   = 17'(in_reg.setpoint) - 17'(in_reg.measured);
    assign db17    = $signed({2'b00, cfg.dead_band});
    assign in_band = (e_raw < db17) && (e_raw > -db17);
    assign e_dz    = in_band ? 17'sd0 : e_raw;
    assign de      = 18'(err_reg) - 18'(prev_err_reg);

    // round to nearest, ties up: add half then arithmetic shift
    assign prod_rnd = (prod + MUL_P_W'(128)) >>> 8;
    assign inc      = prod_rnd[41:0];

    // integral update and clamp, Q.28
    assign acc_sum = 42'(acc_reg) + inc;
    assign ilim    = $signed({11'b0, cfg.integral_limit, 16'b0});
    always_comb
    begin
        priority if (acc_sum > ilim)
        begin
            acc_clamped = ilim[31:0];
        end
        else if (acc_sum < -ilim)
        begin
            acc_clamped = 32'(-ilim);
        end
        else
        begin
            acc_clamped = acc_sum[31:0];
        end
    end
    assign i_rnd  = (34'(acc_reg) + 34'sd32768) >>> 16;
    assign i_term = i_rnd[16:0];

    // derivative: sign-magnitude into the serial divider, truncation toward zero
    assign dvd     = $signed({prod[33:0], 8'b0});
    assign dvd_mag = dvd[41] ? -dvd : dvd;
    assign div_mag = dvd_mag[DIV_N_W-1:0];
    assign d_term  = d_neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});

    assign olim = $signed({28'b0, cfg.output_limit});

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        prev_err_next  = prev_err_reg;
        acc_next       = acc_reg;
        in_next        = in_reg;
        err_next       = err_reg;
        p_next         = p_reg;
        d_neg_next     = d_neg_reg;
        sum_next       = sum_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        mul_a          = '0;
        mul_b          = '0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_item;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                err_next = e_dz;
                if (in_reg.step_time == '0)
                begin
                    // invalid time step: zero drive, state untouched
                    res_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                mul_a      = MUL_A_W'(cfg.deriv_gain);
                mul_b      = de;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                d_neg_next = dvd[41];
                mul_a      = MUL_A_W'(cfg.prop_gain);
                mul_b      = MUL_B_W'(err_reg);
                state_next = ST_MUL_I1;
            end
            ST_MUL_I1:
            begin
                p_next     = prod_rnd[24:0];
                mul_a      = MUL_A_W'(cfg.integ_gain);
                mul_b      = MUL_B_W'(err_reg);
                state_next = ST_MUL_I2;
            end
            ST_MUL_I2:
            begin
                mul_a      = prod[MUL_A_W-1:0];
                mul_b      = $signed({2'b00, in_reg.step_time});
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                acc_next      = acc_clamped;
                prev_err_next = err_reg;
                state_next    = ST_WAIT_DIV;
            end
            ST_WAIT_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next   = 43'(p_reg) + 43'(i_term) + 43'(d_term);
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                priority if (sum_reg > olim)
                begin
                    res_next.drive     = olim[15:0];
                    res_next.saturated = 1'b1;
                end
                else if (sum_reg < -olim)
                begin
                    res_next.drive     = 16'(-olim);
                    res_next.saturated = 1'b1;
                end
                else
                begin
                    res_next.drive     = sum_reg[15:0];
                    res_next.saturated = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            prev_err_reg  <= '0;
            acc_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            prev_err_reg  <= prev_err_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg       <= in_next;
        err_reg      <= err_next;
        p_reg        <= p_next;
        d_neg_reg    <= d_neg_next;
        sum_reg      <= sum_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ design/pdc_cfg.sv @@
// Configuration register file of the deadband PID controller.
`timescale 1ns / 1ps

module pdc_cfg
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output pdc_cfg_t              cfg
);

    pdc_cfg_t cfg_reg;
    pdc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROP_GAIN:      cfg_next.prop_gain      = cfg_data;
                CFG_INTEG_GAIN:     cfg_next.integ_gain     = cfg_data;
                CFG_DERIV_GAIN:     cfg_next.deriv_gain     = cfg_data;
                CFG_OUTPUT_LIMIT:   cfg_next.output_limit   = cfg_data[14:0];
                CFG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[14:0];
                CFG_DEAD_BAND:      cfg_next.dead_band      = cfg_data[14:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= PROP_GAIN_RST;
            cfg_reg.integ_gain     <= INTEG_GAIN_RST;
            cfg_reg.deriv_gain     <= DERIV_GAIN_RST;
            cfg_reg.output_limit   <= OUTPUT_LIMIT_RST;
            cfg_reg.integral_limit <= INTEGRAL_LIMIT_RST;
            cfg_reg.dead_band      <= DEAD_BAND_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/pdc_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module pdc_mul
    import pdc_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [MUL_P_W-1:0] prod
);

    logic signed [MUL_P_W-1:0] prod_reg;
    logic signed [MUL_P_W-1:0] prod_next;

    assign prod_next = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

@@ design/pdc_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module pdc_div
    import pdc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic               busy,
    output logic [DIV_N_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_D_W-1:0]   rem_reg, rem_next;
    logic [DIV_D_W-1:0]   dv_reg, dv_next;
    logic [DIV_N_W-1:0]   quo_reg, quo_next;
    logic [DIV_D_W:0]     trial;
    logic [DIV_D_W:0]     diff;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff  = trial - {1'b0, dv_reg};
    assign fits  = (trial >= {1'b0, dv_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_N_W - 1);
            rem_next  = '0;
            dv_next   = divisor;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

@@ design/pdc_chk.sv @@
// Port-level checker for the deadband PID controller, bound to the top level.
`timescale 1ns / 1ps

module pdc_chk
    import pdc_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     in_valid,
    input logic     in_stall,
    input pdc_in_t  in_item,
    input logic     out_valid,
    input logic     out_stall,
    input pdc_out_t out_item
);

    // one item in flight: the block holds off the next one after accepting
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while a previous item was still in work");

    // a new result only shows up after the block has been working on an item
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without an item in work");

    // a result held by the receiver stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("stalled result changed or dropped");

    // an input item held off by the block stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(in_item)))
        else $error("stalled input item changed or dropped");

    // a saturated result never carries the most negative code
    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.saturated) |-> (out_item.drive != 16'sh8000))
        else $error("saturated drive outside the limit range");

endmodule

bind pid_deadband_clamped pdc_chk u_pdc_chk (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the deadband PID controller with clamped integral.
`timescale 1ns / 1ps

module tb_top;
    import pdc_pkg::*;

    // Indexes with no register behind them; writes there must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Quiet cycles allowed on both channels before the run is declared hung.
    // Phase changes add a short pause.
    localparam int QUIET_LIMIT = 3000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    pdc_in_t               in_item = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    pdc_out_t              out_item;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_PROP_GAIN;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    pid_deadband_clamped uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Items waiting to be offered, and drive values expected back, in order.
    pdc_in_t  stim_q[$];
    pdc_out_t drive_q[$];

    // Percent of cycles in which the sender idles / the receiver stalls.
    int unsigned idle_pct  = 29;
    int unsigned stall_pct = 29;

    int n_fail = 0;
    int quiet  = 0;

    // Controller copy kept by the testbench: register values and loop state.
    pdc_cfg_t ctl_regs = '{
        prop_gain:      PROP_GAIN_RST,
        integ_gain:     INTEG_GAIN_RST,
        deriv_gain:     DERIV_GAIN_RST,
        output_limit:   OUTPUT_LIMIT_RST,
        integral_limit: INTEGRAL_LIMIT_RST,
        dead_band:      DEAD_BAND_RST
    };
    longint err_last  = 0;   // error of the last step with nonzero dt, Q.12
    longint integ_sum = 0;   // accumulated integral, Q.28

    initial
    begin
        forever #5 clk = ~clk;
    end

    // One control step: returns the expected drive and advances the loop state.
    function automatic pdc_out_t pid_predict(input pdc_in_t x);
        longint e, dt, kp, ki, kd, db, ilim, olim, p, ival, d, total;
        pdc_out_t r;
        r = '0;
        // zero dt: output 0, state untouched
        if (x.step_time == 16'd0)
            return r;
        dt   = longint'(x.step_time);
        kp   = longint'($signed(ctl_regs.prop_gain));
        ki   = longint'($signed(ctl_regs.integ_gain));
        kd   = longint'($signed(ctl_regs.deriv_gain));
        db   = longint'(ctl_regs.dead_band);
        ilim = longint'(ctl_regs.integral_limit) * 65536;
        olim = longint'(ctl_regs.output_limit);
        e = longint'($signed(x.setpoint)) - longint'($signed(x.measured));
        // strictly inside the band only; a zero band zeroes nothing
        if (e < db && e > -db)
            e = 0;
        // rounding is floor(x / 2^s + 1/2), i.e. ties go up
        p = (kp * e + 128) >>> 8;
        integ_sum = integ_sum + ((ki * e * dt + 128) >>> 8);
        // re-clamped every step, so a lowered limit bites at once
        if (integ_sum > ilim)
            integ_sum = ilim;
        else if (integ_sum < -ilim)
            integ_sum = -ilim;
        ival = (integ_sum + 32768) >>> 16;
        // signed divide truncates toward zero
        d = (kd * (e - err_last) * 256) / dt;
        err_last = e;
        total = p + ival + d;
        if (total > olim)
        begin
            total = olim;
            r.saturated = 1'b1;
        end
        else if (total < -olim)
        begin
            total = -olim;
            r.saturated = 1'b1;
        end
        r.drive = total[15:0];
        return r;
    endfunction

    task automatic push_item(input int sp, input int ms, input int dt);
        pdc_in_t x;
        x.setpoint  = sp[15:0];
        x.measured  = ms[15:0];
        x.step_time = dt[15:0];
        stim_q.push_back(x);
    endtask

    // Only called while nothing is in flight, so the local copy can follow at once.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_PROP_GAIN:      ctl_regs.prop_gain      = val;
            CFG_INTEG_GAIN:     ctl_regs.integ_gain     = val;
            CFG_DERIV_GAIN:     ctl_regs.deriv_gain     = val;
            CFG_OUTPUT_LIMIT:   ctl_regs.output_limit   = val[14:0];
            CFG_INTEGRAL_LIMIT: ctl_regs.integral_limit = val[14:0];
            CFG_DEAD_BAND:      ctl_regs.dead_band      = val[14:0];
            default:            ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [15:0] kp, input logic [15:0] ki,
                             input logic [15:0] kd, input logic [15:0] olim,
                             input logic [15:0] ilim, input logic [15:0] db);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_INTEG_GAIN, ki);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_OUTPUT_LIMIT, olim);
        write_reg(CFG_INTEGRAL_LIMIT, ilim);
        write_reg(CFG_DEAD_BAND, db);
    endtask

    // Hold the sender off until every queued item is in and every drive is back.
    // Checked on the falling edge so queue and valid values have settled.
    task automatic drain();
        do
            @(negedge clk);
        while (stim_q.size() != 0 || in_valid || drive_q.size() != 0);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    // Limits are 15 bits wide; bit 15 of the data is sent anyway and dropped.
    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3, 4:    return 16'($urandom);
            default: return 16'($urandom_range(0, 4095));
        endcase
    endfunction

    // Random sample: full-range values, errors right at the band edge, or a
    // small tracking error around the set point, with a spread of step times.
    task automatic push_random();
        int e, db, lo, hi, ms, dt;
        db = int'(ctl_regs.dead_band);
        case ($urandom_range(0, 9))
            0, 1, 2: dt = 0;
            3, 4:    dt = $urandom_range(1, 16);
            5:       dt = 65535;
            default: dt = $urandom_range(1, 65535);
        endcase
        if (dt == 0 && $urandom_range(0, 2) != 0)
            dt = $urandom_range(1, 65535);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
            begin
                push_item(int'($urandom_range(0, 65535)) - 32768,
                          int'($urandom_range(0, 65535)) - 32768, dt);
                return;
            end
            4, 5, 6: e = db + int'($urandom_range(0, 2)) - 1;
            default: e = int'($urandom_range(0, 2 * db + 128)) - db - 64;
        endcase
        if ($urandom_range(0, 1))
            e = -e;
        if (e > 32767)
            e = 32767;
        if (e < -32768)
            e = -32768;
        // pick the measurement so that setpoint = measured + e stays in range
        lo = (e < 0) ? -32768 - e : -32768;
        hi = (e > 0) ? 32767 - e : 32767;
        ms = lo + int'($urandom_range(0, hi - lo));
        push_item(ms + e, ms, dt);
    endtask

    // Sender: offers the next queued item once the current one is taken.
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (stim_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                in_valid <= 1'b1;
                in_item  <= stim_q.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Every accepted item yields exactly one expected drive value.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            drive_q.push_back(pid_predict(in_item));
    end

    always @(posedge clk)
    begin : result_check
        pdc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $error("unexpected result: drive %0d saturated %0b",
                       $signed(out_item.drive), out_item.saturated);
                n_fail++;
            end
            else
            begin
                want = drive_q.pop_front();
                if (out_item.drive !== want.drive)
                begin
                    $error("drive: expected %0d, got %0d",
                           $signed(want.drive), $signed(out_item.drive));
                    n_fail++;
                end
                if (out_item.saturated !== want.saturated)
                begin
                    $error("saturated: expected %0b, got %0b",
                           want.saturated, out_item.saturated);
                    n_fail++;
                end
            end
        end
    end

    // Watchdog: a stretch with no handshake on either channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Reset settings: band edges, zero dt, full-scale errors.
        push_item(0, 0, 0);
        push_item(32767, -32768, 0);
        push_item(81, 0, 100);
        push_item(-81, 0, 100);
        push_item(82, 0, 100);
        push_item(0, 82, 100);
        push_item(32767, -32768, 65535);
        push_item(-32768, 32767, 1);
        push_item(1000, 1000, 65535);
        drain();

        // No dead band; large integral gain winds the integral into its clamp.
        write_all(16'd256, 16'd4096, -16'sd300, 16'h7FFF, 16'h7FFF, 16'd0);
        push_item(1, 0, 1);
        push_item(0, 1, 1);
        push_item(0, 0, 1);
        push_item(32767, -32768, 65535);
        push_item(32767, -32768, 65535);
        push_item(0, 0, 0);
        push_item(32767, -32768, 65535);
        push_item(-32768, 32767, 2);
        drain();

        // Integral limit lowered under a wound-up integral.
        write_reg(CFG_INTEGRAL_LIMIT, 16'd50);
        push_item(100, 0, 10);
        drain();

        // Gain and limit extremes; output limit of zero.
        write_all(16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h7FFF);
        push_item(32767, -32768, 1);
        push_item(-32768, 32767, 65535);
        push_item(5, 3, 7);
        drain();

        write_all(16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'h0000, 16'h0000);
        write_reg(CFG_SPARE_LO, 16'hFFFF);
        write_reg(CFG_SPARE_HI, 16'h5A5A);
        push_item(32767, -32768, 1);
        push_item(-32768, 32767, 1);
        push_item(0, 0, 65535);
        drain();

        // Random phases, each under its own register setting.
        for (int ph = 0; ph < 8; ph++)
        begin
            write_all(pick_gain(), pick_gain(), pick_gain(),
                      pick_limit(), pick_limit(), pick_limit());
            // one phase runs with neither side idling
            idle_pct  = (ph == 3) ? 0 : 29;
            stall_pct = (ph == 3) ? 0 : 29;
            for (int n = 0; n < 100; n++)
                push_random();
            drain();
        end

        repeat (60) @(posedge clk);
        if (drive_q.size() != 0)
        begin
            $error("%0d expected drive values never arrived", drive_q.size());
            n_fail++;
        end
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
